FILE: hw/rtl/assert_macros.svh
// assertion macros used by the framer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define NSF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// expression must never be true outside reset
`define NSF_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

FILE: hw/rtl/nmea_sf_pkg.sv
// types, constants and lookup functions of the nmea sentence framer
package nmea_sf_pkg;

    localparam int BYTE_W  = 8;
    localparam int TYPE_W  = 3;
    localparam int FIELD_W = 6;
    localparam int MASK_W  = 6;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int OUT_W   = 40;

    // special characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    // sentence type codes
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_GGA     = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_GSA     = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_GSV     = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_RMC     = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_GLL     = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_VTG     = 3'd6;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 6'd63;

    // register selects (paddr bit 2)
    localparam logic REG_ENABLED_MASK = 1'b0;
    localparam logic REG_CHECK_ENABLE = 1'b1;

    localparam logic [MASK_W-1:0] ENABLED_MASK_RST = 6'h3F;

    typedef struct packed {
        logic [MASK_W-1:0] enabled_mask;
        logic              check_enable;
    } t_cfg;

    typedef struct packed {
        logic [TYPE_W-1:0]  sentence_type;
        logic               checksum_ok;
        logic [BYTE_W-1:0]  computed_checksum;
        logic [BYTE_W-1:0]  received_checksum;
        logic [FIELD_W-1:0] field_count;
        logic [MASK_W-1:0]  seen_mask;
        logic               all_seen;
    } t_result;

    // three-letter sentence id lookup
    function automatic logic [TYPE_W-1:0] match_type(input logic [23:0] tri_chars);
        logic [TYPE_W-1:0] code;
        case (tri_chars)
            24'h474741: code = TYPE_GGA;
            24'h475341: code = TYPE_GSA;
            24'h475356: code = TYPE_GSV;
            24'h524D43: code = TYPE_RMC;
            24'h474C4C: code = TYPE_GLL;
            24'h565447: code = TYPE_VTG;
            default:    code = TYPE_UNKNOWN;
        endcase
        return code;
    endfunction

    // ascii hex digit: bit 4 flags a valid digit, low nibble is its value
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/nmea_sentence_framer.sv
// top level of the nmea sentence framer: input register, parser, result register
//
//  channel   dir  beat moves                 handshake
//  s         in   one received character     i_s_tvalid / o_s_tready
//  m         out  one sentence result        o_m_tvalid / i_m_tready
//  apb       in   register write / read      psel, penable, pwrite, pready
//
// one character per cycle sustained while no closing byte waits; a byte is
// registered in the input register, is parsed against the sentence state,
// and a carriage return lands its result in the output register
// the parse state update is one compare, xor and counter step per byte
// a byte that closes a sentence waits in the input register only while the
// output register holds an untaken result; all other bytes never stall
// i_rst_n is synchronous, active low; no clearing pass is needed
`include "assert_macros.svh"

module nmea_sentence_framer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] rx_byte
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [2:0] sentence_type, [3] checksum_ok, [11:4] computed_checksum,
    // [19:12] received_checksum, [25:20] field_count, [31:26] seen_mask,
    // [32] all_seen, [39:33] zero
    output logic [nmea_sf_pkg::OUT_W-1:0]    o_m_tdata,
    // apb configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nmea_sf_pkg::PADDR_W-1:0]  paddr,
    input  logic [nmea_sf_pkg::PDATA_W-1:0]  pwdata,
    output logic [nmea_sf_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready
);
    import nmea_sf_pkg::*;

    t_cfg              cfg;
    t_result           res;
    logic              emit;
    logic              out_free;
    logic              advance;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // result register
    logic              r_out_valid;
    t_result           r_out;

    nmea_sf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nmea_sf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_cfg     (cfg),
        .o_emit    (emit),
        .o_res     (res)
    );

    // output slot is free when empty or drained this cycle
    assign out_free = !r_out_valid || i_m_tready;
    // held byte moves on unless it closes a sentence and the slot is busy
    assign advance  = r_in_valid && (!(emit) || out_free);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        {(OUT_W-33){1'b0}},
        r_out.all_seen,
        r_out.seen_mask,
        r_out.field_count,
        r_out.received_checksum,
        r_out.computed_checksum,
        r_out.checksum_ok,
        r_out.sentence_type
    };

    // a result never overwrites one that is still waiting
    `NSF_NEVER(a_no_overwrite, i_clk, i_rst_n, advance && emit && r_out_valid && !i_m_tready)
    // a checksum match means both sums agree
    `NSF_ASSERT(a_sum_ok, i_clk, i_rst_n,
        (r_out_valid && r_out.checksum_ok) |->
            (r_out.computed_checksum == r_out.received_checksum))
    // all_seen only when the reported mask covers every enabled type
    `NSF_ASSERT(a_all_seen, i_clk, i_rst_n,
        (advance && emit && res.all_seen) |=>
            ((r_out.seen_mask & $past(cfg.enabled_mask)) == $past(cfg.enabled_mask)))

endmodule

FILE: hw/rtl/nmea_sf_cfg.sv
// apb register file: enabled type mask and checksum check enable
module nmea_sf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nmea_sf_pkg::PADDR_W-1:0]  paddr,
    input  logic [nmea_sf_pkg::PDATA_W-1:0]  pwdata,
    output logic [nmea_sf_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready,
    output nmea_sf_pkg::t_cfg                o_cfg
);
    import nmea_sf_pkg::*;

    logic [MASK_W-1:0] r_enabled_mask;
    logic              r_check_enable;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled_mask <= ENABLED_MASK_RST;
            r_check_enable <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_ENABLED_MASK: r_enabled_mask <= pwdata[MASK_W-1:0];
                REG_CHECK_ENABLE: r_check_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ENABLED_MASK: prdata = {{(PDATA_W-MASK_W){1'b0}}, r_enabled_mask};
            REG_CHECK_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, r_check_enable};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.enabled_mask = r_enabled_mask;
    assign o_cfg.check_enable = r_check_enable;

endmodule

FILE: hw/rtl/nmea_sf_core.sv
// sentence parser: checksum, field count, type detection and seen mask
module nmea_sf_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [nmea_sf_pkg::BYTE_W-1:0]  i_byte,
    input  nmea_sf_pkg::t_cfg               i_cfg,
    output logic                            o_emit,
    output nmea_sf_pkg::t_result            o_res
);
    import nmea_sf_pkg::*;

    logic               r_started,    n_started;
    logic [BYTE_W-1:0]  r_chk,        n_chk;
    logic               r_after_star, n_after_star;
    logic [FIELD_W-1:0] r_field,      n_field;
    logic [15:0]        r_id_window,  n_id_window;
    logic [TYPE_W-1:0]  r_type,       n_type;
    logic [BYTE_W-1:0]  r_hex,        n_hex;
    logic               r_hex_active, n_hex_active;
    logic [MASK_W-1:0]  r_seen,       n_seen;

    logic [23:0]        tri_chars;
    logic [TYPE_W-1:0]  win_code;
    logic [4:0]         hex_d;
    logic [BYTE_W-1:0]  rx_sum;
    logic               sum_ok;
    logic               accept;
    logic [MASK_W-1:0]  type_bit;
    logic [MASK_W-1:0]  seen_set;
    logic               all_hit;

    assign tri_chars = {r_id_window, i_byte};
    assign win_code  = match_type(tri_chars);
    assign hex_d     = hex_digit(i_byte);
    assign rx_sum    = r_after_star ? r_hex : '0;
    assign sum_ok    = r_after_star && (rx_sum == r_chk);
    assign accept    = !i_cfg.check_enable || sum_ok;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            type_bit[i] = (r_type == TYPE_W'(i + 1));
        end
    end

    assign seen_set = r_seen | type_bit;
    assign all_hit  = accept && ((seen_set & i_cfg.enabled_mask) == i_cfg.enabled_mask);

    assign o_emit = r_started && (i_byte == CH_CR);

    assign o_res.sentence_type     = r_type;
    assign o_res.checksum_ok       = sum_ok;
    assign o_res.computed_checksum = r_chk;
    assign o_res.received_checksum = rx_sum;
    assign o_res.field_count       = r_field;
    assign o_res.seen_mask         = accept ? seen_set : r_seen;
    assign o_res.all_seen          = all_hit;

    always_comb begin
        n_started    = r_started;
        n_chk        = r_chk;
        n_after_star = r_after_star;
        n_field      = r_field;
        n_id_window  = r_id_window;
        n_type       = r_type;
        n_hex        = r_hex;
        n_hex_active = r_hex_active;
        n_seen       = r_seen;
        if (i_byte == CH_DOLLAR) begin
            n_started    = 1'b1;
            n_chk        = '0;
            n_after_star = 1'b0;
            n_field      = '0;
            n_id_window  = '0;
            n_type       = TYPE_UNKNOWN;
            n_hex        = '0;
            n_hex_active = 1'b1;
        end else if (!r_started) begin
            // outside a sentence: ignored
        end else if (i_byte == CH_COMMA || i_byte == CH_STAR) begin
            if (!r_after_star && i_byte == CH_COMMA) begin
                n_chk = r_chk ^ i_byte;
            end
            if (r_after_star || i_byte == CH_STAR) begin
                n_after_star = 1'b1;
                n_hex        = '0;
                n_hex_active = 1'b1;
            end
            if (r_field != FIELD_MAX) begin
                n_field = r_field + 1'b1;
            end
        end else if (i_byte == CH_CR) begin
            n_started = 1'b0;
            if (all_hit) begin
                n_seen = '0;
            end else if (accept) begin
                n_seen = seen_set;
            end
        end else if (!r_after_star) begin
            n_chk = r_chk ^ i_byte;
            if (r_field == '0) begin
                if (win_code > r_type) begin
                    n_type = win_code;
                end
                n_id_window = tri_chars[15:0];
            end
        end else if (r_hex_active) begin
            if (!hex_d[4]) begin
                n_hex_active = 1'b0;
            end else begin
                n_hex = {r_hex[3:0], hex_d[3:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_chk        <= '0;
            r_after_star <= 1'b0;
            r_field      <= '0;
            r_id_window  <= '0;
            r_type       <= TYPE_UNKNOWN;
            r_hex        <= '0;
            r_hex_active <= 1'b1;
            r_seen       <= '0;
        end else if (i_advance) begin
            r_started    <= n_started;
            r_chk        <= n_chk;
            r_after_star <= n_after_star;
            r_field      <= n_field;
            r_id_window  <= n_id_window;
            r_type       <= n_type;
            r_hex        <= n_hex;
            r_hex_active <= n_hex_active;
            r_seen       <= n_seen;
        end
    end

endmodule
